[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the PCM width converter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside of reset.
`define PWCG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// The condition must never be true outside of reset.
`define PWCG_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`endif

[rtl/core/pwcg_pkg.sv]
// ---------------------------------------------------------------------------
// pwcg_pkg
// Types, constants and helper functions of the PCM width converter.
// ---------------------------------------------------------------------------
package pwcg_pkg;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_IN_BYTES     = 3'd0,
        CFG_OUT_BYTES    = 3'd1,
        CFG_CHANNEL_CNT  = 3'd2,
        CFG_GAIN_L       = 3'd3,
        CFG_GAIN_R       = 3'd4
    } t_cfg_index;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [16:0] UNITY_GAIN  = 17'd65536;
    localparam logic [7:0]  U8_OFFSET   = 8'd128;
    localparam logic [2:0]  RST_BYTES   = 3'd2;
    localparam logic [3:0]  RST_CHANNEL = 4'd2;

    // Raw configuration register contents.
    typedef struct packed {
        logic [2:0]  in_bytes;
        logic [2:0]  out_bytes;
        logic [3:0]  channel_count;
        logic [16:0] gain_l;
        logic [16:0] gain_r;
    } t_cfg;

    // One decoded sample word passed from the front to the back.
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [16:0] gain;
        logic [2:0]  ch;
    } t_front_word;

    // Clamp a byte-width code to the range one to four.
    function automatic logic [2:0] width_bytes(input logic [2:0] v);
        logic [2:0] w;
        if (v == 3'd0) begin
            w = 3'd1;
        end else if (v > 3'd4) begin
            w = 3'd4;
        end else begin
            w = v;
        end
        return w;
    endfunction

    // Gains above unity act as unity.
    function automatic logic [16:0] clip_gain(input logic [16:0] g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    // Clamp the channel count to the range one to eight.
    function automatic logic [3:0] clamp_count(input logic [3:0] c);
        logic [3:0] w;
        if (c == 4'd0) begin
            w = 4'd1;
        end else if (c > 4'd8) begin
            w = 4'd8;
        end else begin
            w = c;
        end
        return w;
    endfunction

endpackage

[rtl/core/pwcg_front.sv]
// ---------------------------------------------------------------------------
// pwcg_front
// Decodes an input sample into sign and magnitude, picks the channel gain
// and walks the channel counter.
// ---------------------------------------------------------------------------
module pwcg_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwcg_pkg::t_cfg        i_cfg,
    input  logic                  i_accept,
    input  logic [31:0]           i_sample_in,
    output pwcg_pkg::t_front_word o_word
);
    import pwcg_pkg::*;

    logic [2:0]  r_chan;
    logic [2:0]  n_chan;
    logic [2:0]  w_ib;
    logic [31:0] w_sx;
    logic        w_neg;
    logic [31:0] w_mag;
    logic [16:0] w_lg;
    logic [16:0] w_rg;
    logic [16:0] w_gain;
    logic [3:0]  w_count;
    logic [3:0]  w_ch_inc;

    // Sign and magnitude of the sample at the configured input width.
    always_comb begin
        w_ib = width_bytes(i_cfg.in_bytes);
        w_sx = i_sample_in;
        w_neg = 1'b0;
        w_mag = '0;
        case (w_ib)
            3'd1: begin
                w_neg = ~i_sample_in[7];
                w_mag = i_sample_in[7] ? {25'b0, i_sample_in[6:0]}
                                       : {24'b0, U8_OFFSET - i_sample_in[7:0]};
            end
            3'd2: begin
                w_sx  = {{16{i_sample_in[15]}}, i_sample_in[15:0]};
                w_neg = w_sx[31];
                w_mag = w_neg ? (~w_sx + 32'd1) : w_sx;
            end
            3'd3: begin
                w_sx  = {{8{i_sample_in[23]}}, i_sample_in[23:0]};
                w_neg = w_sx[31];
                w_mag = w_neg ? (~w_sx + 32'd1) : w_sx;
            end
            default: begin
                w_sx  = i_sample_in;
                w_neg = w_sx[31];
                w_mag = w_neg ? (~w_sx + 32'd1) : w_sx;
            end
        endcase
    end

    // Gain by channel: left, right, or the larger of the two.
    always_comb begin
        w_lg = clip_gain(i_cfg.gain_l);
        w_rg = clip_gain(i_cfg.gain_r);
        case (r_chan)
            3'd0:    w_gain = w_lg;
            3'd1:    w_gain = w_rg;
            default: w_gain = (w_lg > w_rg) ? w_lg : w_rg;
        endcase
    end

    // The counter returns to zero at the end of a frame, or when it already
    // sits beyond a lowered channel count.
    always_comb begin
        w_count  = clamp_count(i_cfg.channel_count);
        w_ch_inc = {1'b0, r_chan} + 4'd1;
        n_chan   = r_chan;
        if (i_accept) begin
            n_chan = (w_ch_inc >= w_count) ? 3'd0 : w_ch_inc[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 3'd0;
        end else begin
            r_chan <= n_chan;
        end
    end

    assign o_word.neg  = w_neg;
    assign o_word.mag  = w_mag;
    assign o_word.gain = w_gain;
    assign o_word.ch   = r_chan;

endmodule

[rtl/core/pwcg_queue.sv]
// ---------------------------------------------------------------------------
// pwcg_queue
// Short first-in first-out queue of decoded words between front and back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pwcg_queue #(
    parameter int unsigned DEPTH = pwcg_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pwcg_pkg::t_front_word i_word,
    output logic                  o_full,
    input  logic                  i_pop,
    output pwcg_pkg::t_front_word o_word,
    output logic                  o_empty
);
    import pwcg_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_front_word   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage holds payload only and needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_word = r_mem[r_rd_ptr];

    `PWCG_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `PWCG_ASSERT(a_empty_ptrs, i_clk, i_rst_n, (r_count == '0) |-> (r_rd_ptr == r_wr_ptr))
    `PWCG_ASSERT(a_full_ptrs, i_clk, i_rst_n, o_full |-> (r_rd_ptr == r_wr_ptr))
    `PWCG_ASSERT_NEVER(a_push_lost, i_clk, i_rst_n, w_do_push && (n_count == '0))

endmodule

[rtl/core/pwcg_back.sv]
// ---------------------------------------------------------------------------
// pwcg_back
// Three-stage pipeline: gain multiply, rounding shift, saturation and
// output formatting into the result register.
// ---------------------------------------------------------------------------
module pwcg_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwcg_pkg::t_cfg        i_cfg,
    input  logic                  i_q_valid,
    input  pwcg_pkg::t_front_word i_q_word,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [31:0]           o_sample_out,
    output logic [2:0]            o_channel_index
);
    import pwcg_pkg::*;

    logic        r_s1_valid;
    logic [47:0] r_s1_prod;
    logic        r_s1_neg;
    logic [2:0]  r_s1_ch;
    logic        r_s2_valid;
    logic [55:0] r_s2_r;
    logic        r_s2_neg;
    logic [2:0]  r_s2_ch;
    logic        r_s3_valid;
    logic [31:0] r_s3_out;
    logic [2:0]  r_s3_ch;

    logic        w_s1_load;
    logic        w_s2_load;
    logic        w_s3_load;
    logic [48:0] w_prod;
    logic [2:0]  w_ib;
    logic [2:0]  w_ob;
    logic [2:0]  w_units;
    logic [5:0]  w_rs;
    logic [56:0] w_ext;
    logic [56:0] w_half;
    logic [56:0] w_shifted;
    logic [5:0]  w_obits;
    logic [32:0] w_limit;
    logic [31:0] w_mag_sat;
    logic [31:0] w_val;
    logic [31:0] w_mask;
    logic [31:0] w_out;

    // A stage loads when it is empty or its contents move on this cycle.
    assign w_s3_load = !r_s3_valid || i_pop;
    assign w_s2_load = !r_s2_valid || w_s3_load;
    assign w_s1_load = !r_s1_valid || w_s2_load;
    assign o_q_pop   = w_s1_load;

    // Stage one: magnitude times gain.
    assign w_prod = i_q_word.mag * i_q_word.gain;

    // Stage two: shift by 8 * (3 + in_bytes - out_bytes) from a word that
    // already carries the largest left shift, rounding half up on magnitude.
    always_comb begin
        w_ib      = width_bytes(i_cfg.in_bytes);
        w_ob      = width_bytes(i_cfg.out_bytes);
        w_units   = 3'(4'd3 + {1'b0, w_ib} - {1'b0, w_ob});
        w_rs      = {w_units, 3'b000};
        w_ext     = {1'b0, r_s1_prod, 8'b0};
        w_half    = (w_units >= 3'd2) ? (57'd1 << (w_rs - 6'd1)) : '0;
        w_shifted = (w_ext + w_half) >> w_rs;
    end

    // Stage three: clamp to the output range, apply the sign and format.
    always_comb begin
        w_obits = {w_ob, 3'b000};
        w_limit = 33'd1 << (w_obits - 6'd1);
        if (r_s2_neg) begin
            w_mag_sat = (r_s2_r > {23'b0, w_limit}) ? w_limit[31:0] : r_s2_r[31:0];
            w_val     = ~w_mag_sat + 32'd1;
        end else begin
            w_mag_sat = (r_s2_r > {23'b0, w_limit - 33'd1}) ? 32'(w_limit - 33'd1)
                                                           : r_s2_r[31:0];
            w_val     = w_mag_sat;
        end
        w_mask = (w_ob == 3'd4) ? 32'hFFFF_FFFF : 32'((33'd1 << w_obits) - 33'd1);
        if (w_ob == 3'd1) begin
            w_out = {24'b0, w_val[7:0] + U8_OFFSET};
        end else begin
            w_out = w_val & w_mask;
        end
    end

    // Valid bits of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (w_s1_load) begin
                r_s1_valid <= i_q_valid;
            end
            if (w_s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_s3_load) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (w_s1_load) begin
            r_s1_prod <= w_prod[47:0];
            r_s1_neg  <= i_q_word.neg;
            r_s1_ch   <= i_q_word.ch;
        end
        if (w_s2_load) begin
            r_s2_r   <= w_shifted[55:0];
            r_s2_neg <= r_s1_neg;
            r_s2_ch  <= r_s1_ch;
        end
        if (w_s3_load) begin
            r_s3_out <= w_out;
            r_s3_ch  <= r_s2_ch;
        end
    end

    assign o_empty         = !r_s3_valid;
    assign o_sample_out    = r_s3_out;
    assign o_channel_index = r_s3_ch;

endmodule

[rtl/core/pcm_width_convert_gain.sv]
// ---------------------------------------------------------------------------
// pcm_width_convert_gain
// PCM sample width conversion with per-channel Q1.16 gain, rounding and
// saturation.
// ---------------------------------------------------------------------------
//   Channel   Direction  Handshake                  Payload
//   sample    in         push / full                i_sample_in
//   result    out        pop / empty                o_sample_out, o_channel_index
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while the queue is not full; a result passes
// through the queue and then the multiply, round-shift and saturate stages.
// Reset is synchronous: queue, pipeline and channel counter empty or zero,
// registers at their defaults. A stalled result holds the pipeline while
// the queue keeps taking words until it fills. Configuration is always ready.
// ---------------------------------------------------------------------------
module pcm_width_convert_gain #(
    parameter int unsigned P_QUEUE_DEPTH = pwcg_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_sample_in,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] o_sample_out,
    output logic [2:0]  o_channel_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import pwcg_pkg::*;

    t_cfg        r_cfg;
    t_front_word w_front_word;
    t_front_word w_q_word;
    logic        w_accept;
    logic        w_q_empty;
    logic        w_q_pop;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    // Configuration register file; writes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_bytes      <= RST_BYTES;
            r_cfg.out_bytes     <= RST_BYTES;
            r_cfg.channel_count <= RST_CHANNEL;
            r_cfg.gain_l        <= UNITY_GAIN;
            r_cfg.gain_r        <= UNITY_GAIN;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_IN_BYTES:    r_cfg.in_bytes      <= i_cfg_data[2:0];
                CFG_OUT_BYTES:   r_cfg.out_bytes     <= i_cfg_data[2:0];
                CFG_CHANNEL_CNT: r_cfg.channel_count <= i_cfg_data[3:0];
                CFG_GAIN_L:      r_cfg.gain_l        <= i_cfg_data;
                CFG_GAIN_R:      r_cfg.gain_r        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front: decode and gain selection.
    pwcg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_accept    (w_accept),
        .i_sample_in (i_sample_in),
        .o_word      (w_front_word)
    );

    // Queue between front and back.
    pwcg_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (w_front_word),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_word  (w_q_word),
        .o_empty (w_q_empty)
    );

    // Back: arithmetic pipeline and result register.
    pwcg_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (!w_q_empty),
        .i_q_word        (w_q_word),
        .o_q_pop         (w_q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_sample_out    (o_sample_out),
        .o_channel_index (o_channel_index)
    );

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Testbench of pcm_width_convert_gain. Pushes sample words through the
// queue interface, predicts each converted sample and its channel position
// in a behavioral model kept inside the testbench, and compares every popped
// result with the oldest prediction. Directed tests cover width extremes,
// rounding, gain selection and odd register values. A long random stream
// then runs through many register settings with random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
    import pwcg_pkg::*;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd7;
    localparam int         RUN_WORDS       = 1600;
    localparam int         SETTLE_CYCLES   = 6;

    // One predicted result word.
    typedef struct packed {
        logic [31:0] sample;
        logic [2:0]  channel;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [31:0] i_sample_in;
    logic        pop;
    logic        empty;
    logic [31:0] o_sample_out;
    logic [2:0]  o_channel_index;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [16:0] i_cfg_data;

    // Shadow copy of the register file and of the channel counter.
    logic [2:0]  cfg_in_bytes;
    logic [2:0]  cfg_out_bytes;
    logic [3:0]  cfg_channels;
    logic [16:0] cfg_gain_l;
    logic [16:0] cfg_gain_r;
    logic [2:0]  next_channel;

    t_result     expected_words[$];
    t_result     oldest;
    int          errors;
    bit          no_idle;

    pcm_width_convert_gain uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_in     (i_sample_in),
        .pop             (pop),
        .empty           (empty),
        .o_sample_out    (o_sample_out),
        .o_channel_index (o_channel_index),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on the run time.
    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end

    // Width codes outside one to four are pulled to the nearest legal value.
    function automatic int bytes_used(input logic [2:0] v);
        if (v == 3'd0) begin
            return 1;
        end
        if (v > 3'd4) begin
            return 4;
        end
        return int'(v);
    endfunction

    // Gains never exceed unity.
    function automatic logic [16:0] gain_limited(input logic [16:0] g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    // Converted sample and channel for one raw word at the current settings.
    function automatic t_result convert_word(input logic [31:0] raw);
        int          ib;
        int          ob;
        int          ibits;
        int          obits;
        int          shift;
        logic [16:0] lg;
        logic [16:0] rg;
        logic [16:0] g;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] r;
        logic [63:0] lim;
        logic [63:0] v;
        logic [63:0] off;
        logic        neg;
        t_result     res;
        ib    = bytes_used(cfg_in_bytes);
        ob    = bytes_used(cfg_out_bytes);
        ibits = ib * 8;
        obits = ob * 8;
        off   = {56'd0, U8_OFFSET};
        lg    = gain_limited(cfg_gain_l);
        rg    = gain_limited(cfg_gain_r);
        if (next_channel == 3'd0) begin
            g = lg;
        end else if (next_channel == 3'd1) begin
            g = rg;
        end else begin
            g = (lg > rg) ? lg : rg;
        end

        // Split the sample into sign and magnitude.
        if (ib == 1) begin
            m   = {56'd0, raw[7:0]};
            neg = (m < off);
            mag = neg ? (off - m) : (m - off);
        end else begin
            m   = {32'd0, raw} & ((64'd1 << ibits) - 64'd1);
            neg = m[ibits-1];
            mag = neg ? ((64'd1 << ibits) - m) : m;
        end

        // Scale, round half away from zero and saturate.
        prod  = mag * {47'd0, g};
        shift = obits - ibits - 16;
        if (shift >= 0) begin
            r = prod << shift;
        end else begin
            r = (prod + (64'd1 << (-shift - 1))) >> (-shift);
        end
        lim = 64'd1 << (obits - 1);
        if (neg) begin
            if (r > lim) begin
                r = lim;
            end
            v = -r;
        end else begin
            if (r > lim - 64'd1) begin
                r = lim - 64'd1;
            end
            v = r;
        end

        // Pack into the output format.
        if (ob == 1) begin
            v = (v + off) & 64'hFF;
        end else begin
            v = v & ((64'd1 << obits) - 64'd1);
        end
        res.sample  = v[31:0];
        res.channel = next_channel;
        return res;
    endfunction

    // Queue the expected result of an accepted word and advance the counter.
    task automatic predict_word(input logic [31:0] raw);
        logic [3:0] frame;
        frame = cfg_channels;
        if (frame == 4'd0) begin
            frame = 4'd1;
        end else if (frame > 4'd8) begin
            frame = 4'd8;
        end
        expected_words.insert(expected_words.size(), convert_word(raw));
        if ({1'b0, next_channel} + 4'd1 >= frame) begin
            next_channel = 3'd0;
        end else begin
            next_channel = next_channel + 3'd1;
        end
    endtask

    // Push one word after a random gap; entered and left at a falling edge.
    task automatic send_word(input logic [31:0] w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push        = 1'b1;
        i_sample_in = w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_word(w);
        @(negedge i_clk);
    endtask

    // Hold off input until every expected word has been popped.
    task automatic settle_all();
        push = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write, only ever done with the block idle.
    task automatic write_reg(input logic [2:0] index, input logic [16:0] data);
        settle_all();
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_IN_BYTES:    cfg_in_bytes  = data[2:0];
            CFG_OUT_BYTES:   cfg_out_bytes = data[2:0];
            CFG_CHANNEL_CNT: cfg_channels  = data[3:0];
            CFG_GAIN_L:      cfg_gain_l    = data;
            CFG_GAIN_R:      cfg_gain_r    = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Random sample biased toward the sign boundary of the current width.
    function automatic logic [31:0] random_sample();
        int          bits;
        logic [63:0] boundary;
        logic [31:0] upper;
        logic [31:0] w;
        bits     = bytes_used(cfg_in_bytes) * 8;
        boundary = 64'd1 << (bits - 1);
        upper    = $urandom & ~32'((64'd1 << bits) - 64'd1);
        case ($urandom_range(0, 7))
            0:       w = 32'd0;
            1:       w = 32'hFFFF_FFFF;
            2:       w = boundary[31:0] | upper;
            3:       w = (boundary[31:0] - 32'd1) | upper;
            4:       w = (boundary[31:0] + 32'd1) | upper;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // Random gain with the extremes drawn often.
    function automatic logic [16:0] random_gain();
        logic [16:0] g;
        case ($urandom_range(0, 5))
            0:       g = 17'd0;
            1:       g = UNITY_GAIN;
            2:       g = UNITY_GAIN - 17'd1;
            3:       g = 17'h1FFFF;
            4:       g = 17'($urandom_range(0, 131071));
            default: g = 17'($urandom_range(0, 65536));
        endcase
        return g;
    endfunction

    // Result side: pop after a random stall per word.
    initial begin
        int gap;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                pop = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop = 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compare each popped word with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: sample_out %h channel_index %0d",
                       o_sample_out, o_channel_index);
                errors++;
            end else begin
                oldest = expected_words[0];
                expected_words.delete(0);
                if (o_sample_out !== oldest.sample) begin
                    $error("sample_out: expected %h, got %h", oldest.sample, o_sample_out);
                    errors++;
                end
                if (o_channel_index !== oldest.channel) begin
                    $error("channel_index: expected %0d, got %0d",
                           oldest.channel, o_channel_index);
                    errors++;
                end
            end
        end
    end

    // Reset settings: 16-bit in and out, two channels, unity gains.
    task automatic test_default_setup();
        send_word(32'h0000_0000);
        send_word(32'h0000_7FFF);
        send_word(32'h0000_8000);
        send_word(32'hFFFF_FFFF);
        send_word(32'hA5A5_0001);
    endtask

    // Widest and narrowest conversions, and rounding of exact halves.
    task automatic test_width_extremes();
        write_reg(CFG_IN_BYTES, 17'd1);
        write_reg(CFG_OUT_BYTES, 17'd4);
        send_word(32'h0000_0000);
        send_word(32'h0000_00FF);
        send_word(32'h0000_0080);
        write_reg(CFG_IN_BYTES, 17'd4);
        write_reg(CFG_OUT_BYTES, 17'd1);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        // Magnitude 128 from 16 to 8 bits lands exactly on one half.
        write_reg(CFG_IN_BYTES, 17'd2);
        send_word(32'h0000_0080);
        send_word(32'h0000_FF80);
    endtask

    // Left, right and larger-of-both gain, with a gain above unity.
    task automatic test_gain_select();
        write_reg(CFG_OUT_BYTES, 17'd2);
        write_reg(CFG_CHANNEL_CNT, 17'd3);
        write_reg(CFG_GAIN_L, 17'd0);
        write_reg(CFG_GAIN_R, 17'h1FFFF);
        send_word(32'h0000_7FFF);
        send_word(32'h0000_8000);
        send_word(32'h0000_4000);
    endtask

    // Register values out of range, masked upper data bits, spare index.
    task automatic test_odd_settings();
        write_reg(CFG_IN_BYTES, 17'h1FFF8);
        write_reg(CFG_OUT_BYTES, 17'd7);
        write_reg(CFG_CHANNEL_CNT, 17'h1FFF0);
        send_word(32'h0000_0001);
        send_word(32'h0000_00FE);
        write_reg(CFG_CHANNEL_CNT, 17'd15);
        send_word(32'h0000_007F);
        send_word(32'h0000_0081);
        write_reg(CFG_SPARE_INDEX, 17'h1FFFF);
        send_word(32'hFFFF_FF00);
    endtask

    // Channel count lowered from eight to two after five words.
    task automatic test_count_lowered();
        write_reg(CFG_CHANNEL_CNT, 17'd8);
        repeat (5) send_word($urandom);
        write_reg(CFG_CHANNEL_CNT, 17'd2);
        send_word($urandom);
        send_word($urandom);
    endtask

    // Random stream in phases, each with fresh settings.
    task automatic test_random_stream();
        int          sent;
        int          phase;
        int          n;
        logic [16:0] data;
        sent  = 0;
        phase = 0;
        while (sent < RUN_WORDS) begin
            data = {14'($urandom), 3'($urandom_range(1, 4))};
            if ($urandom_range(0, 7) == 0) begin
                data[2:0] = 3'($urandom_range(0, 7));
            end
            write_reg(CFG_IN_BYTES, data);
            data = {14'($urandom), 3'($urandom_range(1, 4))};
            if ($urandom_range(0, 7) == 0) begin
                data[2:0] = 3'($urandom_range(0, 7));
            end
            write_reg(CFG_OUT_BYTES, data);
            data = {13'($urandom), 4'($urandom_range(1, 8))};
            if ($urandom_range(0, 7) == 0) begin
                data[3:0] = 4'($urandom_range(0, 15));
            end
            write_reg(CFG_CHANNEL_CNT, data);
            write_reg(CFG_GAIN_L, random_gain());
            write_reg(CFG_GAIN_R, random_gain());

            // Every fourth phase runs without gaps on either side.
            no_idle = (phase % 4 == 3);
            n = $urandom_range(20, 120);
            if (n > RUN_WORDS - sent) begin
                n = RUN_WORDS - sent;
            end
            repeat (n) send_word(random_sample());
            sent += n;
            if (phase % 5 == 2) begin
                settle_all();
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        push           = 1'b0;
        i_sample_in    = 32'd0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_IN_BYTES;
        i_cfg_data     = 17'd0;
        errors         = 0;
        no_idle        = 1'b0;
        cfg_in_bytes   = RST_BYTES;
        cfg_out_bytes  = RST_BYTES;
        cfg_channels   = RST_CHANNEL;
        cfg_gain_l     = UNITY_GAIN;
        cfg_gain_r     = UNITY_GAIN;
        next_channel   = 3'd0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_setup();
        test_width_extremes();
        test_gain_select();
        test_odd_settings();
        test_count_lowered();
        test_random_stream();
        settle_all();

        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pwcg_pkg.sv
rtl/core/pwcg_front.sv
rtl/core/pwcg_queue.sv
rtl/core/pwcg_back.sv
rtl/core/pcm_width_convert_gain.sv
verif/tb.sv
